// ----- src/cpfl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpfl_pkg
// Shared types and constants for the chunk pool free-list allocator.
// ----------------------------------------------------------------------------
package cpfl_pkg;

	// pool geometry
	localparam int POOL_CHUNKS = 4096;
	localparam int IDX_W       = 12;
	localparam int CNT_W       = 13;

	// chunks per block after reset
	localparam logic [CNT_W-1:0] PER_BLOCK_RESET = 13'd1024;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// request item
	typedef struct packed {
		logic             mode;
		logic             has_chunk;
		logic [IDX_W-1:0] chunk_index;
	} req_t;

	// response item
	typedef struct packed {
		logic [IDX_W-1:0] granted_index;
		logic             ok;
		logic [CNT_W-1:0] total_chunks;
	} rsp_t;

	// one entry of the link store: successor and list-tail mark
	typedef struct packed {
		logic             tail;
		logic [IDX_W-1:0] link;
	} link_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_busy;
	} dp_status_t;

endpackage : cpfl_pkg
`default_nettype wire

// ----- src/cpfl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpfl_ctrl
// Sequencer: takes a request item, then runs it through the datapath once
// the response register can take the result.
// ----------------------------------------------------------------------------
module cpfl_ctrl
	import cpfl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// handshake and commands
	always_comb begin
		req_ready   = (state_q == ST_IDLE);
		cmd.capture = req_valid && req_ready;
		cmd.exec    = (state_q == ST_EXEC) && !status.rsp_busy;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd.exec) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : cpfl_ctrl
`default_nettype wire

// ----- src/cpfl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpfl_dp
// Datapath: allocator state, link store, block opening and the response
// register.
// ----------------------------------------------------------------------------
module cpfl_dp
	import cpfl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire req_t             req,
	input  wire ctl_cmd_t         cmd,
	output dp_status_t            status,
	input  wire logic             cfg_valid,
	input  wire logic [CNT_W-1:0] cfg_data,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp
);

	localparam logic [CNT_W:0] POOL_LIMIT = (CNT_W+1)'(POOL_CHUNKS);

	// link store, no reset: entries are used only after being written
	link_t link_mem [POOL_CHUNKS];
	link_t link_rd_q;

	req_t             req_q;
	logic [CNT_W-1:0] per_block_q;
	logic [IDX_W-1:0] freed_head_q;
	logic             freed_empty_q;
	logic [CNT_W-1:0] fresh_q;
	logic [CNT_W-1:0] pool_total_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             first_fit;
	logic [CNT_W-1:0] pt_a;
	logic [CNT_W-1:0] fp_a;
	logic [CNT_W:0]   grow_sum;
	logic             grow_fit;
	logic [IDX_W-1:0] head_d;
	logic             empty_d;
	logic [CNT_W-1:0] fresh_d;
	logic [CNT_W-1:0] total_d;
	logic [IDX_W-1:0] grant_d;
	logic             ok_d;
	logic             wr_en;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_block_q <= PER_BLOCK_RESET;
		end else if (cfg_valid) begin
			per_block_q <= cfg_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	// link store: head read every cycle, push written on execute
	always_ff @(posedge clk) begin
		link_rd_q <= link_mem[freed_head_q];
		if (wr_en) begin
			link_mem[req_q.chunk_index] <= '{tail: freed_empty_q, link: freed_head_q};
		end
	end

	// block opening and item execution
	always_comb begin
		first_fit = (pool_total_q == '0) && (per_block_q != '0)
			&& ({1'b0, per_block_q} <= POOL_LIMIT);
		pt_a      = first_fit ? per_block_q : pool_total_q;
		fp_a      = first_fit ? '0 : fresh_q;
		grow_sum  = {1'b0, pt_a} + {1'b0, per_block_q};
		grow_fit  = (per_block_q != '0) && (grow_sum <= POOL_LIMIT);

		head_d  = freed_head_q;
		empty_d = freed_empty_q;
		fresh_d = fp_a;
		total_d = pt_a;
		grant_d = '0;
		ok_d    = 1'b1;
		wr_en   = 1'b0;

		if (req_q.mode == MODE_ALLOC) begin
			if (!freed_empty_q) begin
				grant_d = freed_head_q;
				empty_d = link_rd_q.tail;
				head_d  = link_rd_q.link;
			end else if (fp_a < pt_a) begin
				grant_d = fp_a[IDX_W-1:0];
				fresh_d = fp_a + CNT_W'(1);
			end else if (grow_fit) begin
				grant_d = pt_a[IDX_W-1:0];
				fresh_d = pt_a + CNT_W'(1);
				total_d = grow_sum[CNT_W-1:0];
			end else begin
				ok_d = 1'b0;
			end
		end else if (req_q.has_chunk) begin
			if ({1'b0, req_q.chunk_index} < pt_a) begin
				wr_en   = cmd.exec;
				head_d  = req_q.chunk_index;
				empty_d = 1'b0;
			end else begin
				ok_d = 1'b0;
			end
		end
	end

	// allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freed_head_q  <= '0;
			freed_empty_q <= 1'b1;
			fresh_q       <= '0;
			pool_total_q  <= '0;
		end else if (cmd.exec) begin
			freed_head_q  <= head_d;
			freed_empty_q <= empty_d;
			fresh_q       <= fresh_d;
			pool_total_q  <= total_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= '{granted_index: grant_d, ok: ok_d, total_chunks: total_d};
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;
	assign status.rsp_busy = rsp_valid_q && !rsp_ready;

`ifndef NO_ASSERTIONS
	// fresh chunks never run past the opened blocks
	a_fresh_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= pool_total_q)
		else $error("fresh pointer beyond pool total");

	// pool never grows past the store
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pool_total_q} <= POOL_LIMIT)
		else $error("pool total beyond store size");

	// an accepted push leaves the freed list non-empty
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !freed_empty_q)
		else $error("freed list empty after push");

	// a new response only appears after an execute step
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.exec))
		else $error("response without execute");
`endif

endmodule : cpfl_dp
`default_nettype wire

// ----- src/chunk_pool_free_list_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_pool_free_list_allocator_unit
// Fixed-size chunk allocator with a LIFO freed list and block-wise growth.
// ----------------------------------------------------------------------------
// Each request item is captured in the accept cycle while the link store is
// read at the freed-list head, then executed into the response register once
// that register can take the result. No new item is accepted until the last
// has executed; a response that is not taken holds execution of the next item
// until the response register frees up. The link store needs no clearing pass
// after reset. The user must write chunks_per_block on cfg_data only while the
// block is idle; the block itself does not enforce this.
module chunk_pool_free_list_allocator_unit
	import cpfl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	// sequencer
	cpfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	cpfl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule : chunk_pool_free_list_allocator_unit
`default_nettype wire

// ----- verif/chunk_pool_free_list_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_pool_free_list_allocator_unit_tb
// Sends allocate and free items to the chunk pool allocator with random gaps
// on both handshakes. A shadow of the freed list, the fresh pointer and the
// block growth predicts every response, which is checked field by field.
// ----------------------------------------------------------------------------
module chunk_pool_free_list_allocator_unit_tb;
	import cpfl_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int QUIET_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 155;
	localparam int HOLD_CYCLES   = 40;

	localparam logic [CNT_W-1:0] FULL_BLOCK = CNT_W'(POOL_CHUNKS);

	// shadow pool state and the responses still owed by the block
	class pool_ledger;
		link_t          links [POOL_CHUNKS];
		bit [IDX_W-1:0] freed_head;
		bit             freed_empty;
		bit [CNT_W-1:0] fresh_ptr;
		bit [CNT_W-1:0] pool_total;
		bit [CNT_W-1:0] per_block;
		rsp_t           awaited [$];
		int             mismatches;

		function new();
			freed_head  = '0;
			freed_empty = 1'b1;
			fresh_ptr   = '0;
			pool_total  = '0;
			per_block   = PER_BLOCK_RESET;
			mismatches  = 0;
		endfunction

		// open a block directly above the pool if it fits
		function bit grow_pool();
			if (per_block == 0 || pool_total + per_block > POOL_CHUNKS)
				return 1'b0;
			fresh_ptr  = pool_total;
			pool_total = pool_total + per_block;
			return 1'b1;
		endfunction

		// work out the response to an accepted item and queue it
		function rsp_t note_request(req_t r);
			rsp_t want;
			want    = '0;
			want.ok = 1'b1;
			if (pool_total == 0)
				void'(grow_pool());
			if (r.mode == MODE_ALLOC) begin
				if (!freed_empty) begin
					// pop the most recently freed chunk
					want.granted_index = freed_head;
					freed_empty        = links[freed_head].tail;
					freed_head         = links[freed_head].link;
				end else begin
					// fresh chunk, opening a new block when the current one is used up
					if (fresh_ptr == pool_total)
						void'(grow_pool());
					if (fresh_ptr < pool_total) begin
						want.granted_index = fresh_ptr[IDX_W-1:0];
						fresh_ptr++;
					end else begin
						want.ok = 1'b0;
					end
				end
			end else if (r.has_chunk) begin
				// push onto the freed list unless the chunk lies outside the pool
				if (r.chunk_index < pool_total) begin
					links[r.chunk_index].tail = freed_empty;
					links[r.chunk_index].link = freed_head;
					freed_head                = r.chunk_index;
					freed_empty               = 1'b0;
				end else begin
					want.ok = 1'b0;
				end
			end
			want.total_chunks = pool_total;
			awaited.insert(awaited.size(), want);
			return want;
		endfunction

		task report(string what);
			mismatches++;
			$display("mismatch: %s", what);
		endtask

		// compare a response with the oldest outstanding prediction
		task check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				report($sformatf("response %h with nothing outstanding", got));
				return;
			end
			want = awaited.pop_front();
			if (got.granted_index !== want.granted_index)
				report($sformatf("granted_index got %0d want %0d",
					got.granted_index, want.granted_index));
			if (got.ok !== want.ok)
				report($sformatf("ok got %b want %b", got.ok, want.ok));
			if (got.total_chunks !== want.total_chunks)
				report($sformatf("total_chunks got %0d want %0d",
					got.total_chunks, want.total_chunks));
		endtask
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;

	bit             idle_on      = 1'b0;
	bit             hold_rsp     = 1'b0;
	int             hold_left    = 0;
	int             quiet_cycles = 0;
	bit [IDX_W-1:0] held_chunks [$];
	pool_ledger     book = new();

	chunk_pool_free_list_allocator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// response side: short random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (hold_rsp) begin
			hold_rsp  = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 2);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= arst_n;
		end
	end

	// check every response item taken
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			book.check_response(rsp);
	end

	// stop a hung run
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one request item and wait until it is taken
	task automatic send_request(input req_t r, output rsp_t want);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (!(req_valid && req_ready));
		want = book.note_request(r);
	endtask

	task automatic offer_item(input logic mode, input logic has, input logic [IDX_W-1:0] idx);
		req_t r;
		rsp_t ignored;
		r.mode        = mode;
		r.has_chunk   = has;
		r.chunk_index = idx;
		send_request(r, ignored);
	endtask

	task automatic write_per_block(input logic [CNT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		book.per_block = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering and wait until every response has come back
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (book.awaited.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		rsp_t             want;
		req_t             r;
		int               p;
		int               pick;
		int               roll;
		logic [CNT_W-1:0] setting;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;

		// first block cannot open: zero-size block, then oversized block
		write_per_block('0);
		offer_item(MODE_ALLOC, 1'b1, '1);
		offer_item(MODE_FREE, 1'b1, '0);
		offer_item(MODE_FREE, 1'b0, '1);
		settle();
		write_per_block('1);
		offer_item(MODE_ALLOC, 1'b0, '0);
		offer_item(MODE_FREE, 1'b1, '1);
		settle();

		// one-chunk blocks: growth, lifo reuse, foreign and null frees
		write_per_block(CNT_W'(1));
		offer_item(MODE_ALLOC, 1'b0, '0);
		offer_item(MODE_ALLOC, 1'b0, '0);
		offer_item(MODE_FREE, 1'b1, IDX_W'(0));
		offer_item(MODE_FREE, 1'b1, IDX_W'(1));
		offer_item(MODE_ALLOC, 1'b0, '0);
		offer_item(MODE_ALLOC, 1'b0, '0);
		offer_item(MODE_ALLOC, 1'b1, '1);
		offer_item(MODE_FREE, 1'b1, '1);
		offer_item(MODE_FREE, 1'b0, IDX_W'(2));
		settle();

		// growth refused by a zero block, then by a block that no longer fits
		write_per_block('0);
		offer_item(MODE_ALLOC, 1'b0, '0);
		settle();
		write_per_block(FULL_BLOCK);
		offer_item(MODE_ALLOC, 1'b0, '0);
		offer_item(MODE_FREE, 1'b1, IDX_W'(2));
		offer_item(MODE_ALLOC, 1'b0, '0);

		// random traffic over several block sizes, ending with a full pool
		for (p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: setting = CNT_W'(2);
				1: setting = CNT_W'(1);
				2: setting = CNT_W'(9);
				3: setting = CNT_W'(4);
				4: setting = CNT_W'($urandom_range(1, 64));
				5: setting = CNT_W'(33);
				6: setting = FULL_BLOCK - book.pool_total;
				7: setting = FULL_BLOCK;
				default: setting = CNT_W'(1);
			endcase
			write_per_block(setting);
			idle_on  = (p != 1 && p != 3 && p != PHASES - 1);
			hold_rsp = (p == 1);
			repeat (PHASE_ITEMS) begin
				roll          = $urandom_range(0, 99);
				r.mode        = MODE_ALLOC;
				r.has_chunk   = 1'($urandom_range(0, 1));
				r.chunk_index = IDX_W'($urandom_range(0, POOL_CHUNKS - 1));
				if (roll >= 55 && roll < 85 && held_chunks.size() != 0) begin
					// give back a chunk that is out on loan
					pick          = $urandom_range(0, held_chunks.size() - 1);
					r.mode        = MODE_FREE;
					r.has_chunk   = 1'b1;
					r.chunk_index = held_chunks[pick];
					held_chunks.delete(pick);
				end else if (roll >= 85 && roll < 90) begin
					r.mode      = MODE_FREE;
					r.has_chunk = 1'b0;
				end else if (roll >= 90) begin
					// stray free: outside the pool while it can grow, anywhere once full
					r.mode      = MODE_FREE;
					r.has_chunk = 1'b1;
					if (book.pool_total < FULL_BLOCK)
						r.chunk_index = IDX_W'($urandom_range(POOL_CHUNKS - 1,
							book.pool_total));
				end
				send_request(r, want);
				if (r.mode == MODE_ALLOC && want.ok)
					held_chunks.insert(held_chunks.size(), want.granted_index);
			end
		end

		settle();
		if (book.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
